### rtl/sorted_priority_queue_core_assert.svh
// ----------------------------------------------------------------------------
// sorted priority queue assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH

// condition holds at every edge out of reset
`define SPQ_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("sorted priority queue: invariant violated");

// consequence holds in the cycle after the antecedent
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted priority queue: request outcome wrong");

`endif

### rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// types and codes shared by the sorted priority queue cells and top level
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int VAL_W = 32;
  localparam int PRI_W = 16;
  localparam int ST_W  = 2;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_REMOVE = 1'b1
  } spq_mode_t;

  typedef enum logic [ST_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } spq_status_t;

  // operation broadcast to every cell
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [PRI_W-1:0] pri;
    logic [VAL_W-1:0] value;
  } spq_op_t;

endpackage

### rtl/sorted_priority_queue_core.sv
// Result: the outcome of an accepted request is registered into the output register.
// Throughput: one request per cycle while out_tready is high; every cell compares
// and shifts in parallel, and a result left waiting holds off the next request.
// Reset: synchronous active-low rst_n clears the fill count and output valid;
// slot contents are left as they are and only slots below the count are read.
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// sorted-array priority queue built as a row of compare-and-shift cells
// ----------------------------------------------------------------------------
module sorted_priority_queue_core #(
  parameter int DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // item_value [31:0], item_priority [47:32]
  input  logic        in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // out_value [31:0], out_priority [47:32]
  output logic [1:0]  out_tuser   // status
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0] out_value_r, out_value_nxt;
  logic [PRI_W-1:0] out_pri_r, out_pri_nxt;
  logic [ST_W-1:0]  status_r, status_nxt;

  logic             in_fire, is_remove, full, empty;
  logic             ins_drop, rem_miss;
  spq_op_t          op;

  logic [DEPTH-1:0] lt;
  logic [VAL_W-1:0] cell_value [DEPTH];
  logic [PRI_W-1:0] cell_pri   [DEPTH];

  assign in_tready = rst_n && (!out_valid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;
  assign is_remove = (in_tuser == MODE_REMOVE);
  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);
  assign ins_drop  = in_fire && !is_remove && full;
  assign rem_miss  = in_fire && is_remove && empty;

  assign op.ins   = in_fire && !is_remove && !full;
  assign op.rem   = in_fire && is_remove && !empty;
  assign op.value = in_tdata[VAL_W-1:0];
  assign op.pri   = in_tdata[VAL_W+PRI_W-1:VAL_W];

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic             left_lt;
    logic [VAL_W-1:0] left_value, right_value;
    logic [PRI_W-1:0] left_pri, right_pri;

    if (k == 0) begin : g_head
      assign left_lt    = 1'b0;
      assign left_value = '0;
      assign left_pri   = '0;
    end else begin : g_mid
      assign left_lt    = lt[k-1];
      assign left_value = cell_value[k-1];
      assign left_pri   = cell_pri[k-1];
    end

    if (k == DEPTH - 1) begin : g_end
      assign right_value = cell_value[k];
      assign right_pri   = cell_pri[k];
    end else begin : g_inner
      assign right_value = cell_value[k+1];
      assign right_pri   = cell_pri[k+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .op         (op),
      .cell_valid (count_r > CNT_W'(k)),
      .tail       (count_r == CNT_W'(k)),
      .left_lt    (left_lt),
      .left_value (left_value),
      .left_pri   (left_pri),
      .right_value(right_value),
      .right_pri  (right_pri),
      .lt         (lt[k]),
      .value      (cell_value[k]),
      .pri        (cell_pri[k])
    );
  end

  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_pri_nxt   = out_pri_r;
    status_nxt    = status_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = '0;
      out_pri_nxt   = '0;
      if (!is_remove) begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_INSERTED;
          count_nxt  = count_r + 1'b1;
        end
      end else begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          status_nxt    = ST_REMOVED;
          out_value_nxt = cell_value[0];
          out_pri_nxt   = cell_pri[0];
          count_nxt     = count_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_value_r <= out_value_nxt;
    out_pri_r   <= out_pri_nxt;
    status_r    <= status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_pri_r, out_value_r};
  assign out_tuser  = status_r;

`include "sorted_priority_queue_core_assert.svh"

  `SPQ_ASSERT_ALWAYS(a_count_bound, count_r <= CNT_W'(DEPTH))
  `SPQ_ASSERT_NEXT(a_full_drop, ins_drop, out_tvalid && out_tuser == ST_FULL && full)
  `SPQ_ASSERT_NEXT(a_empty_flag, rem_miss, out_tvalid && out_tuser == ST_EMPTY && out_tdata == '0)
  `SPQ_ASSERT_NEXT(a_insert_count, op.ins, count_r == $past(count_r) + 1'b1)

endmodule

### rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted array: compares against the new entry, shifts
// toward the tail on insert and toward the head on remove
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                    clk,
  input  spq_pkg::spq_op_t        op,
  input  logic                    cell_valid,
  input  logic                    tail,
  input  logic                    left_lt,
  input  logic [spq_pkg::VAL_W-1:0] left_value,
  input  logic [spq_pkg::PRI_W-1:0] left_pri,
  input  logic [spq_pkg::VAL_W-1:0] right_value,
  input  logic [spq_pkg::PRI_W-1:0] right_pri,
  output logic                    lt,
  output logic [spq_pkg::VAL_W-1:0] value,
  output logic [spq_pkg::PRI_W-1:0] pri
);
  import spq_pkg::*;

  logic [VAL_W-1:0] value_r, value_nxt;
  logic [PRI_W-1:0] pri_r, pri_nxt;

  assign lt    = cell_valid && (pri_r < op.pri);
  assign value = value_r;
  assign pri   = pri_r;

  always_comb begin
    value_nxt = value_r;
    pri_nxt   = pri_r;
    if (op.ins) begin
      if (left_lt) begin
        value_nxt = left_value;
        pri_nxt   = left_pri;
      end else if (lt || tail) begin
        value_nxt = op.value;
        pri_nxt   = op.pri;
      end
    end else if (op.rem) begin
      value_nxt = right_value;
      pri_nxt   = right_pri;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    pri_r   <= pri_nxt;
  end

endmodule
